### sv/square_matrix_arith_unit_core_defines.svh
// assertion macros for the square matrix arithmetic unit
// sampled on clk_i, disabled while rst_ni is low
`ifndef SQUARE_MATRIX_ARITH_UNIT_CORE_DEFINES_SVH
`define SQUARE_MATRIX_ARITH_UNIT_CORE_DEFINES_SVH

// same-cycle implication
`define SMAU_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMAU_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

### sv/smau_pkg.sv
// shared constants, codes, command struct and address helper
// for the square matrix arithmetic unit; no dependencies
`default_nettype none
package smau_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_W     = 32;
  localparam int ROW_W      = 3;
  localparam int CELLS      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int DIM_W      = 4;
  localparam int OP_W       = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(3);

  localparam logic [MODE_W-1:0] MODE_WR_A    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_B    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP  = 1'd1;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    logic              exe;
    logic              mul;
    logic              sub;
    logic              acc;
    logic              acc_first;
  } smau_cmd_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

endpackage
`default_nettype wire

### sv/smau_in_if.sv
// input channel: load and compute words
// depends on smau_pkg
`default_nettype none
interface smau_in_if import smau_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [ROW_W-1:0]         row;
  logic [ROW_W-1:0]         col;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink   (input valid, mode, row, col, value, output ready);
endinterface
`default_nettype wire

### sv/smau_out_if.sv
// output channel: result element words
// depends on smau_pkg
`default_nettype none
interface smau_out_if import smau_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [ROW_W-1:0]         out_row;
  logic [ROW_W-1:0]         out_col;
  logic signed [DATA_W-1:0] out_value;
  logic                     last;

  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, last, output ready);
endinterface
`default_nettype wire

### sv/smau_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module smau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### sv/smau_datapath.sv
// datapath: matrix a and b storage, valid bits, single mac unit
// depends on smau_pkg and smau_ram
`default_nettype none
module smau_datapath import smau_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire smau_cmd_t         cmd_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  output logic      [DATA_W-1:0] res_o
);

  logic [CELLS-1:0]  va_q, va_d, vb_q, vb_d;
  logic [ADDR_W-1:0] ra_q, rb_q;
  logic [DATA_W-1:0] a_rd, b_rd, a_op, b_op;
  logic [DATA_W-1:0] prod_q, prod_d, acc_q, acc_d;

  smau_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_a),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (wr_data_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_a_addr),
    .rdata_o (a_rd)
  );

  smau_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_b),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (wr_data_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_b_addr),
    .rdata_o (b_rd)
  );

  // never-written cells read as zero
  assign a_op = va_q[ra_q] ? a_rd : '0;
  assign b_op = vb_q[rb_q] ? b_rd : '0;

  always_comb begin
    va_d = va_q;
    vb_d = vb_q;
    if (cmd_i.wr_a) begin
      va_d[cmd_i.wr_addr] = 1'b1;
    end
    if (cmd_i.wr_b) begin
      vb_d[cmd_i.wr_addr] = 1'b1;
    end
  end

  always_comb begin
    prod_d = prod_q;
    acc_d  = acc_q;
    if (cmd_i.exe) begin
      if (cmd_i.mul) begin
        prod_d = a_op * b_op;
      end else if (cmd_i.sub) begin
        acc_d = a_op - b_op;
      end else begin
        acc_d = a_op + b_op;
      end
    end
    if (cmd_i.acc) begin
      acc_d = (cmd_i.acc_first ? '0 : acc_q) + prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
      vb_q <= '0;
    end else begin
      va_q <= va_d;
      vb_q <= vb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      ra_q <= cmd_i.rd_a_addr;
      rb_q <= cmd_i.rd_b_addr;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign res_o = acc_q;

endmodule
`default_nettype wire

### sv/smau_ctrl.sv
// controller: load decode, element and k counters, sequencing fsm
// depends on smau_pkg
`default_nettype none
module smau_ctrl import smau_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [MODE_W-1:0] in_mode_i,
  input  wire logic [ROW_W-1:0]  in_row_i,
  input  wire logic [ROW_W-1:0]  in_col_i,
  input  wire logic [DIM_W-1:0]  dim_i,
  input  wire logic [OP_W-1:0]   op_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [ROW_W-1:0]  out_row_o,
  output logic      [ROW_W-1:0]  out_col_o,
  output logic                   out_last_o,
  output smau_cmd_t              cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EXE  = 5'b00100,
    S_ACC  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [ROW_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [ROW_W-1:0] n_last;
  logic             in_range, is_mul, last_elem;

  // effective dimension minus one
  always_comb begin
    if (dim_i == '0) begin
      n_last = '0;
    end else if (dim_i > DIM_W'(MAX_DIM)) begin
      n_last = ROW_W'(MAX_DIM - 1);
    end else begin
      n_last = ROW_W'(dim_i - DIM_W'(1));
    end
  end

  assign in_range  = (in_row_i <= n_last) && (in_col_i <= n_last);
  assign is_mul    = (op_i == OP_MUL);
  assign last_elem = (i_q == n_last) && (j_q == n_last);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign out_row_o   = i_q;
  assign out_col_o   = j_q;
  assign out_last_o  = last_elem;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.wr_addr   = cell_addr(in_row_i, in_col_i);
    cmd_o.rd_a_addr = is_mul ? cell_addr(i_q, k_q) : cell_addr(i_q, j_q);
    cmd_o.rd_b_addr = is_mul ? cell_addr(k_q, j_q) : cell_addr(i_q, j_q);
    cmd_o.mul       = is_mul;
    cmd_o.sub       = (op_i == OP_SUB);
    cmd_o.acc_first = (k_q == '0);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.wr_a = (in_mode_i == MODE_WR_A) && in_range;
          cmd_o.wr_b = (in_mode_i == MODE_WR_B) && in_range;
          if (in_mode_i == MODE_COMPUTE) begin
            i_d     = '0;
            j_d     = '0;
            k_d     = '0;
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EXE;
      end
      S_EXE: begin
        cmd_o.exe = 1'b1;
        state_d   = is_mul ? S_ACC : S_EMIT;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (k_q == n_last) begin
          k_d     = '0;
          state_d = S_EMIT;
        end else begin
          k_d     = k_q + ROW_W'(1);
          state_d = S_RD;
        end
      end
      S_EMIT: begin
        if (out_ready_i) begin
          if (last_elem) begin
            state_d = S_IDLE;
          end else begin
            if (j_q == n_last) begin
              j_d = '0;
              i_d = i_q + ROW_W'(1);
            end else begin
              j_d = j_q + ROW_W'(1);
            end
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

endmodule
`default_nettype wire

### sv/square_matrix_arith_unit_core.sv
// load word: accepted while idle; compute word emits n*n elements, n = effective dim
// add/subtract: per element a ram read, the alu, then the output register
// multiply: per element on one mac, a read, multiply and accumulate for each k, then output
// one word at a time; a stalled output holds the unit
// async active-low reset: dim 3, operation add, fsm idle, valid bits clear (matrices read 0)
// top level; depends on smau_pkg, smau_in_if, smau_out_if, smau_ctrl, smau_datapath
`default_nettype none
`include "square_matrix_arith_unit_core_defines.svh"
module square_matrix_arith_unit_core import smau_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  smau_in_if.sink                    in_i,
  smau_out_if.source                 out_o
);

  logic [DIM_W-1:0]  dim_q;
  logic [OP_W-1:0]   op_q;
  smau_cmd_t         cmd;
  logic [DATA_W-1:0] res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_RST;
      op_q  <= OP_ADD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIM: dim_q <= cfg_data_i[DIM_W-1:0];
        CFG_OP:  op_q  <= cfg_data_i[OP_W-1:0];
        default: ;
      endcase
    end
  end

  smau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_mode_i   (in_i.mode),
    .in_row_i    (in_i.row),
    .in_col_i    (in_i.col),
    .dim_i       (dim_q),
    .op_i        (op_q),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_row_o   (out_o.out_row),
    .out_col_o   (out_o.out_col),
    .out_last_o  (out_o.last),
    .cmd_o       (cmd)
  );

  smau_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .wr_data_i (in_i.value),
    .res_o     (res)
  );

  assign out_o.out_value = res;

  `SMAU_ASSERT_NOW(a_no_overlap, out_o.valid, !in_i.ready, "input ready while result pending")
  `SMAU_ASSERT_NEXT(a_idle_after_last, out_o.valid && out_o.ready && out_o.last, in_i.ready, "not idle after last word")
  `SMAU_ASSERT_NEXT(a_compute_busy, in_i.valid && in_i.ready && (in_i.mode == MODE_COMPUTE), !in_i.ready && !out_o.valid, "compute word not started")

endmodule
`default_nettype wire
